[src/segint_pkg.sv]
// Shared constants for the segment intersection block.
package segint_pkg;

    // Result tuser bit positions.
    localparam int unsigned USER_HIT       = 0;
    localparam int unsigned USER_COLLINEAR = 1;
    localparam int unsigned USER_WIDTH     = 2;

endpackage

[src/segment_intersection.sv]
// Pipelined two-segment intersection test with exact cross products and rounded meet point.
//
// Each input beat carries two segments P (p_start to p_end) and Q (q_start to q_end) in
// signed fixed point. The block forms r = p_end - p_start, s = q_end - q_start and
// d = q_start - p_start. It then computes r x s, d x r, d x s and the dot products
// exactly, with no rounding. From these it reports a collinear overlap, a miss, or a
// proper hit. For a proper hit it gives p_start + t*r, rounded to nearest with halves
// away from zero. The number of fraction bits does not change any result bit, so it is
// not a parameter here.
// Timing: one beat is accepted every cycle unless the pipe is stalled. The stages are four
// arithmetic stages (differences, products, sums, decisions), then one restoring step
// per magnitude bit of r (COORD_WIDTH + 1 stages, x and y lanes side by side), then the
// rounding and output register. The whole pipe advances whenever the output register
// is empty or being taken, so back-pressure stalls it without losing or repeating beats.
module segment_intersection
    import segint_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // low to high: p_start_x, p_start_y, p_end_x, p_end_y,
    //              q_start_x, q_start_y, q_end_x, q_end_y
    input  logic [8*COORD_WIDTH-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // low to high: meet_x, meet_y, zero padding to whole bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // low to high: hit, collinear_overlap
    output logic [USER_WIDTH-1:0]            m_tuser
);

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned DW    = W + 1;          // coordinate differences
    localparam int unsigned PW    = 2 * DW;         // single products
    localparam int unsigned CW    = PW + 1;         // cross / dot sums
    localparam int unsigned RW    = CW + 1;         // divider remainder
    localparam int unsigned QW    = W + 2;          // quotient
    localparam int unsigned STEPS = DW;             // one step per bit of |r|
    localparam int unsigned OW    = ((2*W+7)/8)*8;

    typedef logic signed [W-1:0]  crd_t;
    typedef logic signed [DW-1:0] dif_t;
    typedef logic signed [PW-1:0] prd_t;
    typedef logic signed [CW-1:0] sum_t;

    // Values that ride along the divider stages.
    typedef struct packed {
        logic          valid;
        logic          hit;
        logic          col;
        logic          pt;
        logic          negx;
        logic          negy;
        crd_t          px;
        crd_t          py;
        logic [RW-1:0] n;
        logic [RW-1:0] d;
        logic [DW-1:0] mx;
        logic [DW-1:0] my;
    } car_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
    } lane_t;

    logic en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------- stage 1: differences
    crd_t in_c [0:7];
    logic v1_reg;
    crd_t px1_reg, py1_reg;
    dif_t rx_reg, ry_reg, sx_reg, sy_reg, dx_reg, dy_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            in_c[i] = s_tdata[i*W +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg <= in_c[0];
            py1_reg <= in_c[1];
            rx_reg  <= DW'(in_c[2]) - DW'(in_c[0]);
            ry_reg  <= DW'(in_c[3]) - DW'(in_c[1]);
            sx_reg  <= DW'(in_c[6]) - DW'(in_c[4]);
            sy_reg  <= DW'(in_c[7]) - DW'(in_c[5]);
            dx_reg  <= DW'(in_c[4]) - DW'(in_c[0]);
            dy_reg  <= DW'(in_c[5]) - DW'(in_c[1]);
        end
    end

    // ---------------------------------------------------------------- stage 2: products
    logic v2_reg;
    crd_t px2_reg, py2_reg;
    dif_t rx2_reg, ry2_reg;
    prd_t rxsy_reg, rysx_reg, dxry_reg, dyrx_reg, dxsy_reg, dysx_reg;
    prd_t dxrx_reg, dyry_reg, rxrx_reg, ryry_reg, dxsx_reg, dysy_reg, sxsx_reg, sysy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            rx2_reg  <= rx_reg;
            ry2_reg  <= ry_reg;
            rxsy_reg <= PW'(rx_reg) * PW'(sy_reg);
            rysx_reg <= PW'(ry_reg) * PW'(sx_reg);
            dxry_reg <= PW'(dx_reg) * PW'(ry_reg);
            dyrx_reg <= PW'(dy_reg) * PW'(rx_reg);
            dxsy_reg <= PW'(dx_reg) * PW'(sy_reg);
            dysx_reg <= PW'(dy_reg) * PW'(sx_reg);
            dxrx_reg <= PW'(dx_reg) * PW'(rx_reg);
            dyry_reg <= PW'(dy_reg) * PW'(ry_reg);
            rxrx_reg <= PW'(rx_reg) * PW'(rx_reg);
            ryry_reg <= PW'(ry_reg) * PW'(ry_reg);
            dxsx_reg <= PW'(dx_reg) * PW'(sx_reg);
            dysy_reg <= PW'(dy_reg) * PW'(sy_reg);
            sxsx_reg <= PW'(sx_reg) * PW'(sx_reg);
            sysy_reg <= PW'(sy_reg) * PW'(sy_reg);
        end
    end

    // ---------------------------------------------------------------- stage 3: sums
    logic v3_reg;
    crd_t px3_reg, py3_reg;
    dif_t rx3_reg, ry3_reg;
    sum_t rxs_reg, dxr_reg, dxs_reg, ddr_reg, drr_reg, dds_reg, dss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            rx3_reg <= rx2_reg;
            ry3_reg <= ry2_reg;
            rxs_reg <= CW'(rxsy_reg) - CW'(rysx_reg);
            dxr_reg <= CW'(dxry_reg) - CW'(dyrx_reg);
            dxs_reg <= CW'(dxsy_reg) - CW'(dysx_reg);
            ddr_reg <= CW'(dxrx_reg) + CW'(dyry_reg);
            drr_reg <= CW'(rxrx_reg) + CW'(ryry_reg);
            dds_reg <= CW'(dxsx_reg) + CW'(dysy_reg);
            dss_reg <= CW'(sxsx_reg) + CW'(sysy_reg);
        end
    end

    // ---------------------------------------------------------------- stage 4: decisions
    logic                 rxs_zero, dxr_zero, span_r, span_s, t_ok, u_ok;
    logic signed [CW:0]   ss_plus_ds, dxs_w, rxs_w, dxs_abs, rxs_abs;
    logic signed [DW:0]   rx_w, ry_w, rx_abs, ry_abs;
    car_t                 car4;

    always_comb
    begin
        rxs_zero   = (rxs_reg == '0);
        dxr_zero   = (dxr_reg == '0);
        span_r     = (ddr_reg >= 0) && (ddr_reg <= drr_reg);
        ss_plus_ds = (CW+1)'(dss_reg) + (CW+1)'(dds_reg);
        span_s     = (dds_reg <= 0) && (ss_plus_ds >= 0);
        // 0 <= num/den <= 1 without dividing
        if (rxs_reg > 0)
        begin
            t_ok = (dxs_reg >= 0) && (dxs_reg <= rxs_reg);
            u_ok = (dxr_reg >= 0) && (dxr_reg <= rxs_reg);
        end
        else
        begin
            t_ok = (dxs_reg <= 0) && (dxs_reg >= rxs_reg);
            u_ok = (dxr_reg <= 0) && (dxr_reg >= rxs_reg);
        end
        dxs_w   = (CW+1)'(dxs_reg);
        rxs_w   = (CW+1)'(rxs_reg);
        dxs_abs = dxs_w[CW] ? -dxs_w : dxs_w;
        rxs_abs = rxs_w[CW] ? -rxs_w : rxs_w;
        rx_w    = (DW+1)'(rx3_reg);
        ry_w    = (DW+1)'(ry3_reg);
        rx_abs  = rx_w[DW] ? -rx_w : rx_w;
        ry_abs  = ry_w[DW] ? -ry_w : ry_w;

        car4.valid = v3_reg;
        car4.col   = rxs_zero && dxr_zero && (span_r || span_s);
        car4.pt    = !rxs_zero && t_ok && u_ok;
        car4.hit   = car4.col || car4.pt;
        car4.negx  = (dxs_reg[CW-1] ^ rxs_reg[CW-1]) ^ rx3_reg[DW-1];
        car4.negy  = (dxs_reg[CW-1] ^ rxs_reg[CW-1]) ^ ry3_reg[DW-1];
        car4.px    = px3_reg;
        car4.py    = py3_reg;
        car4.n     = RW'(unsigned'(dxs_abs));
        car4.d     = RW'(unsigned'(rxs_abs));
        car4.mx    = rx_abs[DW-1:0];
        car4.my    = ry_abs[DW-1:0];
    end

    // ---------------------------------------------------------------- divider stages
    // Index 0 is the decision register; index k+1 holds the state after step k.
    car_t  car_reg [0:STEPS];
    lane_t lx_reg  [0:STEPS];
    lane_t ly_reg  [0:STEPS];

    // One step of floor(n * m / d): shift in the next bit of m.
    function automatic lane_t div_step(lane_t cur, logic [RW-1:0] n, logic [RW-1:0] d,
                                       logic mb);
        lane_t         res;
        logic [RW-1:0] r1;
        logic [RW-1:0] r2;
        logic [QW-1:0] q1;
        r1 = {cur.rem[RW-2:0], 1'b0};
        q1 = {cur.q[QW-2:0], 1'b0};
        if (r1 >= d)
        begin
            r1 = r1 - d;
            q1 = q1 + QW'(1);
        end
        r2 = r1;
        if (mb)
        begin
            r2 = r1 + n;
            if (r2 >= d)
            begin
                r2 = r2 - d;
                q1 = q1 + QW'(1);
            end
        end
        res.rem = r2;
        res.q   = q1;
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_reg[0] <= '0;
            lx_reg[0]  <= '0;
            ly_reg[0]  <= '0;
        end
        else if (en)
        begin
            car_reg[0] <= car4;
            lx_reg[0]  <= '0;
            ly_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                car_reg[k+1] <= '0;
                lx_reg[k+1]  <= '0;
                ly_reg[k+1]  <= '0;
            end
            else if (en)
            begin
                car_reg[k+1] <= car_reg[k];
                lx_reg[k+1]  <= div_step(lx_reg[k], car_reg[k].n, car_reg[k].d,
                                         car_reg[k].mx[STEPS-1-k]);
                ly_reg[k+1]  <= div_step(ly_reg[k], car_reg[k].n, car_reg[k].d,
                                         car_reg[k].my[STEPS-1-k]);
            end
        end
    end

    // ---------------------------------------------------------------- round and output
    car_t                 cf;
    lane_t                lfx, lfy;
    logic [QW-1:0]        qx_r, qy_r;
    logic signed [W+2:0]  offx, offy, sumx, sumy;
    logic                 out_valid_reg, out_hit_reg, out_col_reg;
    crd_t                 meet_x_reg, meet_y_reg;

    always_comb
    begin
        cf   = car_reg[STEPS];
        lfx  = lx_reg[STEPS];
        lfy  = ly_reg[STEPS];
        // remainder at least half the divisor: round up (magnitude, so halves go away)
        qx_r = lfx.q + QW'({lfx.rem[RW-2:0], 1'b0} >= cf.d);
        qy_r = lfy.q + QW'({lfy.rem[RW-2:0], 1'b0} >= cf.d);
        offx = cf.negx ? -(W+3)'(qx_r) : (W+3)'(qx_r);
        offy = cf.negy ? -(W+3)'(qy_r) : (W+3)'(qy_r);
        sumx = (W+3)'(cf.px) + offx;
        sumy = (W+3)'(cf.py) + offy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_col_reg   <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cf.valid;
            out_hit_reg   <= cf.hit;
            out_col_reg   <= cf.col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meet_x_reg <= cf.pt ? sumx[W-1:0] : '0;
            meet_y_reg <= cf.pt ? sumy[W-1:0] : '0;
        end
    end

    assign m_tvalid                 = out_valid_reg;
    assign m_tdata                  = OW'({meet_y_reg, meet_x_reg});
    assign m_tuser[USER_HIT]        = out_hit_reg;
    assign m_tuser[USER_COLLINEAR]  = out_col_reg;

endmodule
